// ===== rtl/fvst_pkg.sv =====
// Shared types, constants and arctangent table for the field-of-view sector test.
`default_nettype none

package fvst_pkg;

    // Coordinate width is fixed by the item format.
    localparam int unsigned COORD_BITS = 16;
    localparam int unsigned ANGLE_BITS = 13;
    localparam int unsigned QUAD_BITS = 11;
    localparam int unsigned PRE_SHIFT = 24;
    localparam int unsigned TABLE_LEN = 24;
    localparam int unsigned ARCTAN_STAGES_DEF = 16;

    // Rotation datapath: magnitude plus pre-scale plus CORDIC growth plus sign.
    localparam int unsigned XW = COORD_BITS + PRE_SHIFT + 4;
    // Angle accumulator in 1/65536 degree.
    localparam int unsigned ZW = 25;
    localparam int unsigned DW = COORD_BITS + 1;

    localparam logic [ANGLE_BITS-1:0] FULL_CIRCLE = ANGLE_BITS'(5760);
    localparam logic [ANGLE_BITS-1:0] HALF_CIRCLE = ANGLE_BITS'(2880);
    localparam logic [QUAD_BITS-1:0] QUARTER = QUAD_BITS'(1440);
    localparam logic signed [ZW-1:0] Z_MAX = ZW'(90 * 65536);
    localparam logic [ANGLE_BITS-1:0] WIDTH_RESET = ANGLE_BITS'(960);

    localparam int unsigned IN_BYTES = (4 * COORD_BITS + ANGLE_BITS + 7) / 8;
    localparam int unsigned IN_TDATA_W = 8 * IN_BYTES;
    localparam int unsigned OUT_TDATA_W = 8 * ((ANGLE_BITS + 7) / 8);

    // atan(2^-i) in 1/65536 degree, rounded to nearest.
    localparam logic [22:0] ATAN_TAB [TABLE_LEN] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379, 23'd117304, 23'd58666, 23'd29335,
        23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115,
        23'd57, 23'd29, 23'd14, 23'd7,
        23'd4, 23'd2, 23'd1, 23'd0
    };

    // Side information that rides along the rotation stages.
    typedef struct packed {
        logic [ANGLE_BITS-1:0] head;
        logic                  dx_neg;
        logic                  dy_neg;
        logic                  ax_zero;
        logic                  ay_zero;
    } meta_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        meta_t                meta;
    } cordic_t;

endpackage

`default_nettype wire

// ===== rtl/fvst_cordic_stage.sv =====
// One registered CORDIC vectoring iteration with a fixed shift.
`default_nettype none

module fvst_cordic_stage
    import fvst_pkg::*;
#(
    parameter int unsigned SHIFT = 0
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire cordic_t in_item,
    output logic         out_valid,
    output cordic_t      out_item
);

    localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_TAB[SHIFT]);

    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;
    logic                 y_pos;
    cordic_t              item_next;
    cordic_t              item_reg;
    logic                 valid_reg;

    // Arithmetic shifts round toward minus infinity.
    assign x_sh  = $signed(in_item.x) >>> SHIFT;
    assign y_sh  = $signed(in_item.y) >>> SHIFT;
    assign y_pos = !in_item.y[XW-1] && (in_item.y != '0);

    always_comb
    begin
        item_next = in_item;
        if (y_pos)
        begin
            item_next.x = $signed(in_item.x) + y_sh;
            item_next.y = $signed(in_item.y) - x_sh;
            item_next.z = $signed(in_item.z) + STEP;
        end
        else
        begin
            item_next.x = $signed(in_item.x) - y_sh;
            item_next.y = $signed(in_item.y) + x_sh;
            item_next.z = $signed(in_item.z) - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/field_of_view_sector_test_unit.sv =====
// Top level of the field-of-view sector test: bearing by pipelined CORDIC and sector check.
`default_nettype none

// Each input item carries an observer position, the observer heading and a target
// position; the block returns one result item with the bearing from observer to
// target (0..5759 in 1/16 degree, counterclockwise from the x axis) in m_tdata and
// an in-view flag in m_tuser. The flag is set when twice the circular distance
// between bearing and heading is at most the configured view width; a width of
// 5760 or more always reports in view. The pipeline accepts one item every clock
// cycle while its output slots are not both full. After an item is accepted,
// stages 1 and 2 form and condition the offset, one register stage per CORDIC
// iteration follows, then three stages clamp and round the angle, map it to its
// quadrant and form the distance to the heading, and an output register with a
// skid buffer holds the result. Back-pressure on the result side only stops the
// input once both output slots are full. The view width register may be written
// only while no item is in flight.

module field_of_view_sector_test_unit
    import fvst_pkg::*;
#(
    parameter int unsigned ARCTAN_STAGES = ARCTAN_STAGES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration: view_width.
    input  wire logic                   cfg_wr_en,
    input  wire logic [ANGLE_BITS-1:0]  cfg_wr_data,
    // Input items. s_tdata from bit 0 up: observer_x, observer_y, heading,
    // target_x, target_y, zero fill.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result items. m_tdata from bit 0 up: bearing, zero fill. m_tuser: in_view.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tuser
);

    // View width register.
    logic [ANGLE_BITS-1:0] view_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_reg <= WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            view_width_reg <= cfg_wr_data;
        end
    end

    // The whole pipeline moves together; it stops only when the skid slot is full.
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Field extraction from the input item.
    logic [COORD_BITS-1:0] obs_x;
    logic [COORD_BITS-1:0] obs_y;
    logic [ANGLE_BITS-1:0] head_in;
    logic [COORD_BITS-1:0] tgt_x;
    logic [COORD_BITS-1:0] tgt_y;

    assign obs_x   = s_tdata[COORD_BITS-1:0];
    assign obs_y   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign head_in = s_tdata[2*COORD_BITS+ANGLE_BITS-1:2*COORD_BITS];
    assign tgt_x   = s_tdata[3*COORD_BITS+ANGLE_BITS-1:2*COORD_BITS+ANGLE_BITS];
    assign tgt_y   = s_tdata[4*COORD_BITS+ANGLE_BITS-1:3*COORD_BITS+ANGLE_BITS];

    // Stage 1: offsets and heading reduced modulo a full circle.
    logic signed [DW-1:0]  dx_next;
    logic signed [DW-1:0]  dy_next;
    logic [ANGLE_BITS-1:0] head1_next;
    logic signed [DW-1:0]  dx_reg;
    logic signed [DW-1:0]  dy_reg;
    logic [ANGLE_BITS-1:0] head1_reg;
    logic                  v1_reg;

    assign dx_next = $signed({tgt_x[COORD_BITS-1], tgt_x})
                   - $signed({obs_x[COORD_BITS-1], obs_x});
    assign dy_next = $signed({tgt_y[COORD_BITS-1], tgt_y})
                   - $signed({obs_y[COORD_BITS-1], obs_y});
    assign head1_next = (head_in >= FULL_CIRCLE) ? (head_in - FULL_CIRCLE) : head_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            head1_reg <= head1_next;
        end
    end

    // Stage 2: magnitudes, axis flags and the pre-scaled starting vector.
    logic [DW-1:0] ax;
    logic [DW-1:0] ay;
    cordic_t       c0_next;
    cordic_t       c_item  [ARCTAN_STAGES+1];
    logic          c_valid [ARCTAN_STAGES+1];
    cordic_t       c0_reg;
    logic          v2_reg;

    assign ax = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign ay = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    always_comb
    begin
        c0_next.x            = $signed(XW'(ax) << PRE_SHIFT);
        c0_next.y            = $signed(XW'(ay) << PRE_SHIFT);
        c0_next.z            = '0;
        c0_next.meta.head    = head1_reg;
        c0_next.meta.dx_neg  = dx_reg[DW-1];
        c0_next.meta.dy_neg  = dy_reg[DW-1];
        c0_next.meta.ax_zero = (ax == '0);
        c0_next.meta.ay_zero = (ay == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= c0_next;
        end
    end

    assign c_item[0]  = c0_reg;
    assign c_valid[0] = v2_reg;

    // CORDIC vectoring, one register stage per iteration.
    for (genvar k = 0; k < ARCTAN_STAGES; k++)
    begin : g_cordic
        fvst_cordic_stage #(
            .SHIFT (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_valid[k]),
            .in_item   (c_item[k]),
            .out_valid (c_valid[k+1]),
            .out_item  (c_item[k+1])
        );
    end

    // Stage A: clamp the first-quadrant angle to [0, 90 deg] and round to 1/16 degree.
    cordic_t               c_last;
    logic signed [ZW-1:0]  z_clamped;
    logic signed [ZW-1:0]  z_rounded;
    logic [QUAD_BITS-1:0]  qa_next;
    logic [QUAD_BITS-1:0]  qa_reg;
    meta_t                 meta_a_reg;
    logic                  va_reg;

    assign c_last = c_item[ARCTAN_STAGES];

    always_comb
    begin
        if (c_last.z[ZW-1])
        begin
            z_clamped = '0;
        end
        else if ($signed(c_last.z) > Z_MAX)
        begin
            z_clamped = Z_MAX;
        end
        else
        begin
            z_clamped = c_last.z;
        end
        z_rounded = (z_clamped + ZW'(2048)) >>> 12;
        // An offset on an axis takes the exact angle and skips the rotation result.
        if (c_last.meta.ay_zero)
        begin
            qa_next = '0;
        end
        else if (c_last.meta.ax_zero)
        begin
            qa_next = QUARTER;
        end
        else
        begin
            qa_next = z_rounded[QUAD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= c_valid[ARCTAN_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qa_reg     <= qa_next;
            meta_a_reg <= c_last.meta;
        end
    end

    // Stage B: map the angle to its quadrant; a full circle wraps to zero.
    logic [ANGLE_BITS-1:0] q_ext;
    logic [ANGLE_BITS-1:0] b_next;
    logic [ANGLE_BITS-1:0] b_reg;
    logic [ANGLE_BITS-1:0] head_b_reg;
    logic                  vb_reg;

    assign q_ext = ANGLE_BITS'(qa_reg);

    always_comb
    begin
        unique case ({meta_a_reg.dy_neg, meta_a_reg.dx_neg})
            2'b00:   b_next = q_ext;
            2'b01:   b_next = HALF_CIRCLE - q_ext;
            2'b11:   b_next = HALF_CIRCLE + q_ext;
            default: b_next = (q_ext == '0) ? '0 : (FULL_CIRCLE - q_ext);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg      <= b_next;
            head_b_reg <= meta_a_reg.head;
        end
    end

    // Stage C: angle from heading to bearing, modulo a full circle.
    logic signed [ANGLE_BITS:0] diff;
    logic [ANGLE_BITS-1:0]      d_next;
    logic [ANGLE_BITS-1:0]      d_reg;
    logic [ANGLE_BITS-1:0]      b_c_reg;
    logic                       vc_reg;

    assign diff   = $signed({1'b0, b_reg}) - $signed({1'b0, head_b_reg});
    assign d_next = diff[ANGLE_BITS] ? ANGLE_BITS'(diff + $signed({1'b0, FULL_CIRCLE}))
                                     : diff[ANGLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_next;
            b_c_reg <= b_reg;
        end
    end

    // Circular distance and the inclusive width test, formed in front of the output slots.
    logic [ANGLE_BITS-1:0] circ_dist;
    logic                  in_view_next;

    assign circ_dist = (d_reg <= HALF_CIRCLE) ? d_reg : (FULL_CIRCLE - d_reg);
    assign in_view_next = (view_width_reg >= FULL_CIRCLE)
                       || ({circ_dist[ANGLE_BITS-2:0], 1'b0} <= view_width_reg);

    // Output register and skid slot. The skid slot catches the item that leaves the
    // pipeline while the output register is full and not taken.
    logic                  out_valid_reg;
    logic [ANGLE_BITS-1:0] out_bearing_reg;
    logic                  out_in_view_reg;
    logic [ANGLE_BITS-1:0] skid_bearing_reg;
    logic                  skid_in_view_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (vc_reg)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_bearing_reg <= skid_bearing_reg;
                out_in_view_reg <= skid_in_view_reg;
            end
        end
        else if (vc_reg)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_bearing_reg <= b_c_reg;
                skid_in_view_reg <= in_view_next;
            end
            else
            begin
                out_bearing_reg <= b_c_reg;
                out_in_view_reg <= in_view_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_bearing_reg);
    assign m_tuser  = out_in_view_reg;

    // The skid slot is only ever filled behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds an item while the output register is empty");

    // A taken output is refilled from the skid slot in the next cycle.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid item was not moved into the output register");

    // Every delivered bearing lies in [0, full circle).
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_bearing_reg < FULL_CIRCLE))
        else $error("bearing out of range");

endmodule

`default_nettype wire
